>>> rtl/rss_pkg.sv
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = 32;
  localparam int SQ_BITS     = 48;
  localparam int WIDE_BITS   = 64;
  localparam int MUL_B_BITS  = 32;
  localparam int ROOT_BITS   = WIDE_BITS / 2;
  localparam int OUT_BITS    = 16;
  localparam int STATUS_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [STATUS_BITS-1:0] status_t;
  localparam status_t STATUS_VALID = 2'd0;
  localparam status_t STATUS_UNDEF = 2'd1;
  localparam status_t STATUS_SAT   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_T1,
    S_MUL_T2,
    S_MUL_D2,
    S_DIV_MEAN,
    S_CHECK,
    S_DIV_VAR,
    S_SQRT_VAR,
    S_DIV_ERR,
    S_SQRT_ERR,
    S_OUTPUT
  } state_t;

endpackage

>>> rtl/rss_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle, product mod 2^64.
module rss_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rss_pkg::WIDE_BITS-1:0]   mcand,
  input  logic [rss_pkg::MUL_B_BITS-1:0]  mplier,
  output logic [rss_pkg::WIDE_BITS-1:0]   product,
  output logic                            done
);

  logic [rss_pkg::WIDE_BITS-1:0]          acc_r;
  logic [rss_pkg::WIDE_BITS-1:0]          a_r;
  logic [rss_pkg::MUL_B_BITS-1:0]         b_r;
  logic [$clog2(rss_pkg::MUL_B_BITS)-1:0] cnt_r;
  logic                                   busy_r;
  logic                                   done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= mcand;
      b_r   <= mplier;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[rss_pkg::WIDE_BITS-2:0], 1'b0};
      b_r <= {1'b0, b_r[rss_pkg::MUL_B_BITS-1:1]};
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

>>> rtl/rss_div.sv
// Restoring divider: one quotient bit per cycle over a 64-bit dividend.
module rss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rss_pkg::WIDE_BITS-1:0] dividend,
  input  logic [rss_pkg::WIDE_BITS-1:0] divisor,
  output logic [rss_pkg::WIDE_BITS-1:0] quotient,
  output logic                          done
);

  logic [rss_pkg::WIDE_BITS-1:0]         rem_r;
  logic [rss_pkg::WIDE_BITS-1:0]         quo_r;
  logic [rss_pkg::WIDE_BITS-1:0]         dvs_r;
  logic [$clog2(rss_pkg::WIDE_BITS)-1:0] cnt_r;
  logic                                  busy_r;
  logic                                  done_r;
  logic [rss_pkg::WIDE_BITS:0]           shifted;
  logic [rss_pkg::WIDE_BITS:0]           diff;
  logic                                  fits;

  assign shifted = {rem_r, quo_r[rss_pkg::WIDE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[rss_pkg::WIDE_BITS-1:0] : shifted[rss_pkg::WIDE_BITS-1:0];
      quo_r <= {quo_r[rss_pkg::WIDE_BITS-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> rtl/rss_sqrt.sv
// Digit-by-digit integer square root: two radicand bits per cycle, floor result.
module rss_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rss_pkg::WIDE_BITS-1:0] radicand,
  output logic [rss_pkg::ROOT_BITS-1:0] root,
  output logic                          done
);

  logic [rss_pkg::WIDE_BITS-1:0]         rad_r;
  logic [rss_pkg::ROOT_BITS:0]           rem_r;
  logic [rss_pkg::ROOT_BITS-1:0]         root_r;
  logic [$clog2(rss_pkg::ROOT_BITS)-1:0] cnt_r;
  logic                                  busy_r;
  logic                                  done_r;
  logic [rss_pkg::ROOT_BITS+2:0]         r2;
  logic [rss_pkg::ROOT_BITS+2:0]         trial;
  logic [rss_pkg::ROOT_BITS+2:0]         diff;
  logic                                  fits;

  assign r2    = {rem_r, rad_r[rss_pkg::WIDE_BITS-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign diff  = r2 - trial;
  assign fits  = r2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder stays below 2*root+1, so ROOT_BITS+1 bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[rss_pkg::ROOT_BITS:0] : r2[rss_pkg::ROOT_BITS:0];
      root_r <= {root_r[rss_pkg::ROOT_BITS-2:0], fits};
      rad_r  <= {rad_r[rss_pkg::WIDE_BITS-3:0], 2'b00};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/running_sample_statistics.sv
// Running sample statistics. Each request carries a signed Q7.8 sample (tdata)
// and a restart flag (tuser) that clears count, sum and sum of squares before
// the sample is added. Each request yields exactly one result: the mean
// (truncated toward zero), the sample standard deviation and the standard
// error of the mean as unsigned Q8.8 (floor of exact integer roots, capped at
// 65535), the sample count, and a status code: 0 valid, 1 sigma undefined (a
// single sample or zero spread, both deviations read 0), 2 count saturated
// (the sample was dropped, statistics of the held data are reported). The
// three long products, the divisions and the roots are bit serial: a
// shift-add multiplier (32 bit steps), a restoring divider (64 bit steps)
// and a square-root unit (32 steps), run one after another. When sigma is
// undefined a request passes update, three products, the mean division,
// check and output; otherwise the two divisions and two roots come between
// check and output. The next request can be accepted in the cycle after
// the result is loaded. The result sits in an output register, so a new
// request is taken as soon as the previous one has been handed to it, even
// if it is not yet taken; a result still waiting there when the next one is
// ready holds the sequencer in its output state.
module running_sample_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] mean, [31:16] sigma, [47:32] mean_error,
                                  // [63:48] sample_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int WB = rss_pkg::WIDE_BITS;

  rss_pkg::state_t state_r, state_nxt;
  logic            go_r;

  logic [rss_pkg::SAMPLE_BITS-1:0] sample_r;
  logic                            restart_r;
  logic                            sat_r;
  logic [rss_pkg::COUNT_BITS-1:0]  count_r;
  logic [rss_pkg::SUM_BITS-1:0]    sum_r;
  logic [rss_pkg::SQ_BITS-1:0]     sq_r;
  logic [WB-1:0]                   t1_r;
  logic [WB-1:0]                   num_r;
  logic [2*rss_pkg::COUNT_BITS-1:0] d1_r;
  logic [WB-1:0]                   d2_r;
  logic [rss_pkg::OUT_BITS-1:0]    mean_r, sigma_r, merr_r;
  rss_pkg::status_t                stat_r;

  logic [63:0]      out_data_r;
  logic [1:0]       out_user_r;
  logic             out_valid_r;

  // unit handshakes
  logic                           mul_start, div_start, sqrt_start;
  logic [WB-1:0]                  mul_a, div_n, div_d;
  logic [rss_pkg::MUL_B_BITS-1:0] mul_b;
  logic [WB-1:0]                  mul_p, div_q;
  logic [rss_pkg::ROOT_BITS-1:0]  sqrt_q;
  logic                           mul_done, div_done, sqrt_done;

  logic                           in_acc;
  logic [rss_pkg::SUM_BITS-1:0]   abs_sum;
  logic [rss_pkg::COUNT_BITS-1:0] base_cnt;
  logic [rss_pkg::SUM_BITS-1:0]   base_sum;
  logic [rss_pkg::SQ_BITS-1:0]    base_sq;
  logic [rss_pkg::SAMPLE_BITS-1:0] abs_smp;
  logic [2*rss_pkg::SAMPLE_BITS-1:0] sq_smp;
  logic [WB-1:0]                  mean_q;
  logic                           out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign abs_sum  = sum_r[rss_pkg::SUM_BITS-1] ? -sum_r : sum_r;
  assign abs_smp  = sample_r[rss_pkg::SAMPLE_BITS-1] ? -sample_r : sample_r;
  assign sq_smp   = abs_smp * abs_smp;
  assign base_cnt = restart_r ? '0 : count_r;
  assign base_sum = restart_r ? '0 : sum_r;
  assign base_sq  = restart_r ? '0 : sq_r;
  assign mean_q   = sum_r[rss_pkg::SUM_BITS-1] ? -div_q : div_q;

  rss_mul u_mul (
    .clk, .rst_n, .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .product(mul_p), .done(mul_done)
  );

  rss_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_n), .divisor(div_d),
    .quotient(div_q), .done(div_done)
  );

  rss_sqrt u_sqrt (
    .clk, .rst_n, .start(sqrt_start), .radicand(div_q),
    .root(sqrt_q), .done(sqrt_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rss_pkg::S_IDLE:     if (in_acc) state_nxt = rss_pkg::S_UPDATE;
      rss_pkg::S_UPDATE:   state_nxt = rss_pkg::S_MUL_T1;
      rss_pkg::S_MUL_T1:   if (mul_done) state_nxt = rss_pkg::S_MUL_T2;
      rss_pkg::S_MUL_T2:   if (mul_done) state_nxt = rss_pkg::S_MUL_D2;
      rss_pkg::S_MUL_D2:   if (mul_done) state_nxt = rss_pkg::S_DIV_MEAN;
      rss_pkg::S_DIV_MEAN: if (div_done) state_nxt = rss_pkg::S_CHECK;
      rss_pkg::S_CHECK: begin
        if (count_r < rss_pkg::COUNT_BITS'(2) || num_r == '0) state_nxt = rss_pkg::S_OUTPUT;
        else state_nxt = rss_pkg::S_DIV_VAR;
      end
      rss_pkg::S_DIV_VAR:  if (div_done) state_nxt = rss_pkg::S_SQRT_VAR;
      rss_pkg::S_SQRT_VAR: if (sqrt_done) state_nxt = rss_pkg::S_DIV_ERR;
      rss_pkg::S_DIV_ERR:  if (div_done) state_nxt = rss_pkg::S_SQRT_ERR;
      rss_pkg::S_SQRT_ERR: if (sqrt_done) state_nxt = rss_pkg::S_OUTPUT;
      rss_pkg::S_OUTPUT:   if (out_free) state_nxt = rss_pkg::S_IDLE;
      default:             state_nxt = rss_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: launch at most one unit per state
  always_comb begin
    in_tready  = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = '0;
    unique case (state_r)
      rss_pkg::S_IDLE:     in_tready = 1'b1;
      rss_pkg::S_MUL_T1: begin
        mul_start = go_r;
        mul_a     = WB'(sq_r);
        mul_b     = rss_pkg::MUL_B_BITS'(count_r);
      end
      rss_pkg::S_MUL_T2: begin
        mul_start = go_r;
        mul_a     = WB'(abs_sum);
        mul_b     = abs_sum;
      end
      rss_pkg::S_MUL_D2: begin
        mul_start = go_r;
        mul_a     = WB'(d1_r);
        mul_b     = rss_pkg::MUL_B_BITS'(count_r);
      end
      rss_pkg::S_DIV_MEAN: begin
        div_start = go_r;
        div_n     = WB'(abs_sum);
        div_d     = WB'(count_r);
      end
      rss_pkg::S_DIV_VAR: begin
        div_start = go_r;
        div_n     = num_r;
        div_d     = WB'(d1_r);
      end
      rss_pkg::S_DIV_ERR: begin
        div_start = go_r;
        div_n     = num_r;
        div_d     = d2_r;
      end
      rss_pkg::S_SQRT_VAR, rss_pkg::S_SQRT_ERR: sqrt_start = go_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rss_pkg::S_IDLE;
      go_r        <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // arm a unit launch on every state change
      go_r    <= state_nxt != state_r;
      if (state_r == rss_pkg::S_UPDATE && base_cnt != rss_pkg::COUNT_MAX) begin
        count_r <= base_cnt + 1'b1;
        sum_r   <= base_sum + rss_pkg::SUM_BITS'(signed'(sample_r));
        sq_r    <= base_sq + rss_pkg::SQ_BITS'(sq_smp);
      end else if (state_r == rss_pkg::S_UPDATE) begin
        // saturated: drop the sample; a restart clears the count, so this branch
        // is taken only when the count stays at its maximum
        count_r <= base_cnt;
        sum_r   <= base_sum;
        sq_r    <= base_sq;
      end
      if (state_r == rss_pkg::S_OUTPUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r  <= in_tdata;
      restart_r <= in_tuser;
    end
    if (state_r == rss_pkg::S_UPDATE) sat_r <= base_cnt == rss_pkg::COUNT_MAX;
    if (state_r == rss_pkg::S_MUL_T1) begin
      d1_r <= count_r * (count_r - 1'b1);
      if (mul_done) t1_r <= mul_p;
    end
    if (state_r == rss_pkg::S_MUL_T2 && mul_done) num_r <= (t1_r > mul_p) ? t1_r - mul_p : '0;
    if (state_r == rss_pkg::S_MUL_D2 && mul_done) d2_r <= mul_p;
    if (state_r == rss_pkg::S_DIV_MEAN && div_done) begin
      mean_r  <= mean_q[rss_pkg::OUT_BITS-1:0];
      sigma_r <= '0;
      merr_r  <= '0;
      stat_r  <= rss_pkg::STATUS_UNDEF;
    end
    if (state_r == rss_pkg::S_SQRT_VAR && sqrt_done) begin
      sigma_r <= (sqrt_q > rss_pkg::ROOT_BITS'(16'hFFFF)) ? '1 : sqrt_q[rss_pkg::OUT_BITS-1:0];
      stat_r  <= rss_pkg::STATUS_VALID;
    end
    if (state_r == rss_pkg::S_SQRT_ERR && sqrt_done)
      merr_r <= (sqrt_q > rss_pkg::ROOT_BITS'(16'hFFFF)) ? '1 : sqrt_q[rss_pkg::OUT_BITS-1:0];
    if (state_r == rss_pkg::S_OUTPUT && out_free) begin
      out_data_r <= {count_r, merr_r, sigma_r, mean_r};
      out_user_r <= sat_r ? rss_pkg::STATUS_SAT : stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
